// ===== rtl/ctpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ctpm_pkg;

  localparam int COUNT_BITS = 30;
  localparam int DATA_W     = 30;
  localparam int IDX_W      = $clog2(COUNT_BITS);

  localparam logic [DATA_W-1:0] MOD_PRIME    = 30'd1000000007;
  localparam logic [31:0]       MOD_PRIME_X2 = 32'd2000000014;

  // Barrett constant floor(2^60 / p), fits 31 bits
  localparam logic [63:0] MU_WIDE    = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_QUO,
    ST_QP,
    ST_SUB,
    ST_FIX,
    ST_DBL,
    ST_DONE
  } ctpm_state_t;

  typedef struct packed {
    logic             load;
    logic             final_op;
    logic             acc_fix;
    logic             acc_dbl;
    logic             out_load;
    logic [IDX_W-1:0] bit_idx;
  } ctpm_cmd_t;

  typedef struct packed {
    logic exp_bit;
  } ctpm_sts_t;

endpackage

`default_nettype wire

// ===== rtl/ctpm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ctpm_in_if;
  logic                         valid;
  logic                         ready;
  logic [ctpm_pkg::DATA_W-1:0]  item_count;

  modport source (output valid, output item_count, input ready);
  modport sink   (input valid, input item_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/ctpm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ctpm_out_if;
  logic                         valid;
  logic                         ready;
  logic [ctpm_pkg::DATA_W-1:0]  modular_result;

  modport source (output valid, output modular_result, input ready);
  modport sink   (input valid, input modular_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/count_times_pow2_mod_prime_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// n * 2^(n-1) mod 1000000007 for a 30-bit count n.
// items:   sink channel, one count per transfer (valid/ready).
// results: source channel, one residue per item, same order.
// One item is worked at a time. After its transfer, 30 exponent steps run
// MSB first; each is a Barrett modular square (multiply, quotient
// estimate, q*p, subtract, final correction), plus a doubling when the
// exponent bit is set. A last modular multiply by n mod p follows. The
// next item is taken once the result is in the output register. The
// 30x30 multiplier is shared by the squares and the final multiply, with
// the Barrett chain behind it.
// The result sits in an output register, so a new item is taken while a
// finished result waits. If the receiver stalls and a second result is
// finished, the block holds it until the first is taken and accepts no
// new item meanwhile.
// Synchronous reset returns to idle and drops any pending result.
module count_times_pow2_mod_prime_core (
  input  wire logic   clk,
  input  wire logic   rst,
  ctpm_in_if.sink     items,
  ctpm_out_if.source  results
);

  ctpm_pkg::ctpm_cmd_t cmd;
  ctpm_pkg::ctpm_sts_t sts;

  ctpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ctpm_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .item_count     (items.item_count),
    .modular_result (results.modular_result)
  );

`ifndef SYNTH
  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.modular_result < ctpm_pkg::MOD_PRIME))
    else $error("result not reduced below the prime");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !items.ready)
    else $error("input taken while an item is in flight");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !results.valid)
    else $error("result valid after reset");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(!items.ready))
    else $error("result raised without an item in flight");
`endif

endmodule

`default_nettype wire

// ===== rtl/ctpm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctpm_datapath (
  input  wire logic                        clk,
  input  wire ctpm_pkg::ctpm_cmd_t         cmd,
  output ctpm_pkg::ctpm_sts_t              sts,
  input  wire logic [ctpm_pkg::DATA_W-1:0] item_count,
  output logic [ctpm_pkg::DATA_W-1:0]      modular_result
);

  logic [ctpm_pkg::DATA_W-1:0]   expo;
  logic [ctpm_pkg::DATA_W-1:0]   nmod;
  logic [ctpm_pkg::DATA_W-1:0]   acc;
  logic [ctpm_pkg::DATA_W-1:0]   opb;
  logic [2*ctpm_pkg::DATA_W-1:0] prod;
  logic [ctpm_pkg::DATA_W-1:0]   quo;
  logic [31:0]                   qp;
  logic [31:0]                   rem;

  logic [61:0]                   quo_full;
  logic [2*ctpm_pkg::DATA_W-1:0] qp_full;
  logic [ctpm_pkg::DATA_W-1:0]   nmod_next;
  logic [31:0]                   rem_m1;
  logic [31:0]                   rem_m2;
  logic [ctpm_pkg::DATA_W-1:0]   fix_val;
  logic [ctpm_pkg::DATA_W:0]     dbl;
  logic [ctpm_pkg::DATA_W:0]     dbl_m1;
  logic [ctpm_pkg::DATA_W-1:0]   dbl_val;

  // n < 2p, so a single conditional subtract reduces it
  always_comb begin
    if (item_count >= ctpm_pkg::MOD_PRIME) begin
      nmod_next = item_count - ctpm_pkg::MOD_PRIME;
    end else begin
      nmod_next = item_count;
    end
  end

  assign opb = cmd.final_op ? nmod : acc;

  // Barrett: q = ((x >> 29) * mu) >> 31, remainder x - q*p lands in [0, 3p)
  assign quo_full = {31'd0, prod[2*ctpm_pkg::DATA_W-1:29]} * {31'd0, ctpm_pkg::BARRETT_MU};
  assign qp_full  = {{ctpm_pkg::DATA_W{1'b0}}, quo} *
                    {{ctpm_pkg::DATA_W{1'b0}}, ctpm_pkg::MOD_PRIME};

  assign rem_m1 = rem - {2'b00, ctpm_pkg::MOD_PRIME};
  assign rem_m2 = rem - ctpm_pkg::MOD_PRIME_X2;

  always_comb begin
    if (rem >= ctpm_pkg::MOD_PRIME_X2) begin
      fix_val = rem_m2[ctpm_pkg::DATA_W-1:0];
    end else if (rem >= {2'b00, ctpm_pkg::MOD_PRIME}) begin
      fix_val = rem_m1[ctpm_pkg::DATA_W-1:0];
    end else begin
      fix_val = rem[ctpm_pkg::DATA_W-1:0];
    end
  end

  assign dbl    = {acc, 1'b0};
  assign dbl_m1 = dbl - {1'b0, ctpm_pkg::MOD_PRIME};

  always_comb begin
    if (dbl >= {1'b0, ctpm_pkg::MOD_PRIME}) begin
      dbl_val = dbl_m1[ctpm_pkg::DATA_W-1:0];
    end else begin
      dbl_val = dbl[ctpm_pkg::DATA_W-1:0];
    end
  end

  // reduction chain runs every cycle; acc holds still until the fix step
  always_ff @(posedge clk) begin
    prod <= {{ctpm_pkg::DATA_W{1'b0}}, acc} * {{ctpm_pkg::DATA_W{1'b0}}, opb};
    quo  <= quo_full[60:31];
    qp   <= qp_full[31:0];
    rem  <= prod[31:0] - qp;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      expo <= item_count - ctpm_pkg::DATA_W'(1);
      nmod <= nmod_next;
      acc  <= {{(ctpm_pkg::DATA_W-1){1'b0}}, 1'b1};
    end else if (cmd.acc_fix) begin
      acc <= fix_val;
    end else if (cmd.acc_dbl) begin
      acc <= dbl_val;
    end
    if (cmd.out_load) begin
      modular_result <= acc;
    end
  end

  assign sts.exp_bit = expo[cmd.bit_idx];

endmodule

`default_nettype wire

// ===== rtl/ctpm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctpm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ctpm_pkg::ctpm_cmd_t      cmd,
  input  wire ctpm_pkg::ctpm_sts_t sts
);

  ctpm_pkg::ctpm_state_t         state;
  ctpm_pkg::ctpm_state_t         state_next;
  logic [ctpm_pkg::IDX_W-1:0]    bit_idx;
  logic                          is_final;
  logic                          step_done;
  logic                          out_free;

  assign out_free = !out_valid || out_ready;

  // one exponent bit finished: either no doubling needed, or doubling done
  assign step_done = ((state == ctpm_pkg::ST_FIX) && !is_final && !sts.exp_bit) ||
                     (state == ctpm_pkg::ST_DBL);

  always_comb begin
    state_next = state;
    case (state)
      ctpm_pkg::ST_IDLE: begin
        if (in_valid) state_next = ctpm_pkg::ST_MUL;
      end
      ctpm_pkg::ST_MUL: state_next = ctpm_pkg::ST_QUO;
      ctpm_pkg::ST_QUO: state_next = ctpm_pkg::ST_QP;
      ctpm_pkg::ST_QP:  state_next = ctpm_pkg::ST_SUB;
      ctpm_pkg::ST_SUB: state_next = ctpm_pkg::ST_FIX;
      ctpm_pkg::ST_FIX: begin
        if (is_final) begin
          state_next = ctpm_pkg::ST_DONE;
        end else if (sts.exp_bit) begin
          state_next = ctpm_pkg::ST_DBL;
        end else begin
          state_next = ctpm_pkg::ST_MUL;
        end
      end
      ctpm_pkg::ST_DBL: state_next = ctpm_pkg::ST_MUL;
      ctpm_pkg::ST_DONE: begin
        if (out_free) state_next = ctpm_pkg::ST_IDLE;
      end
      default: state_next = ctpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == ctpm_pkg::ST_IDLE);
    cmd.load     = (state == ctpm_pkg::ST_IDLE) && in_valid;
    cmd.final_op = is_final;
    cmd.acc_fix  = (state == ctpm_pkg::ST_FIX);
    cmd.acc_dbl  = (state == ctpm_pkg::ST_DBL);
    cmd.out_load = (state == ctpm_pkg::ST_DONE) && out_free;
    cmd.bit_idx  = bit_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ctpm_pkg::ST_IDLE;
      bit_idx   <= '0;
      is_final  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        bit_idx  <= ctpm_pkg::IDX_W'(ctpm_pkg::COUNT_BITS - 1);
        is_final <= 1'b0;
      end else if (step_done) begin
        if (bit_idx == '0) begin
          is_final <= 1'b1;
        end else begin
          bit_idx <= bit_idx - ctpm_pkg::IDX_W'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/ctpm_residue_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctpm_residue_check (
  input  wire logic clk,
  input  wire logic rst,
  ctpm_in_if        items,
  ctpm_out_if       results,
  output int        mismatch_count,
  output int        pending_results
);

  import ctpm_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic [DATA_W-1:0] expected_residues[$];

  // n * 2^(n-1) mod p, square-and-multiply over n-1 MSB first
  function automatic logic [DATA_W-1:0] count_pow2_residue(input logic [DATA_W-1:0] n);
    logic [63:0] prime;
    logic [63:0] pw;
    logic [63:0] e;
    logic [63:0] prod;
    int          b;
    prime = {34'd0, MOD_PRIME};
    if (n == '0) begin
      return '0;
    end
    e  = {34'd0, n} - 64'd1;
    pw = 64'd1;
    for (b = COUNT_BITS - 1; b >= 0; b--) begin
      pw = (pw * pw) % prime;
      if (e[b]) begin
        pw = (pw * 64'd2) % prime;
      end
    end
    prod = (pw * ({34'd0, n} % prime)) % prime;
    return prod[DATA_W-1:0];
  endfunction

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (!rst) begin
      if (items.valid && items.ready) begin
        expected_residues.push_back(count_pow2_residue(items.item_count));
      end
      if (results.valid && results.ready) begin
        if (expected_residues.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: unexpected result %0d, nothing pending", $realtime,
                     results.modular_result);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_residues.pop_front();
          if (results.modular_result !== want) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("%0t: modular_result mismatch: expected %0d, actual %0d", $realtime,
                       want, results.modular_result);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    pending_results <= expected_residues.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  import ctpm_pkg::*;

  localparam int RANDOM_ITEMS = 1030;
  localparam int PHASE_LEN    = 350;
  localparam int DRAIN_CYCLES = 200;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   mismatch_count;
  int   pending_results;

  ctpm_in_if  items ();
  ctpm_out_if results ();

  count_times_pow2_mod_prime_core DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results)
  );

  ctpm_residue_check u_check (
    .clk             (clk),
    .rst             (rst),
    .items           (items),
    .results         (results),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // result-side back-pressure
  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      results.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_count(input logic [DATA_W-1:0] n);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      items.valid <= 1'b0;
      @(negedge clk);
    end
    items.valid      <= 1'b1;
    items.item_count <= n;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] random_count();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0, 1: return DATA_W'($urandom_range(64));
      2:    return MOD_PRIME - DATA_W'(8) + DATA_W'($urandom_range(16));
      3:    return {DATA_W{1'b1}} - DATA_W'($urandom_range(16));
      4:    return DATA_W'(1) << $urandom_range(DATA_W - 1);
      default: return r[DATA_W-1:0];
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0] directed[$];
    int                i;
    items.valid      = 1'b0;
    items.item_count = '0;
    send_idle_pct    = 11;
    recv_idle_pct    = 59;
    rst              = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero count, smallest counts, prime neighborhood (n = p gives 0), all ones
    directed = '{30'd0, 30'd1, 30'd2, 30'd3, 30'd4, 30'd5, 30'd31, 30'd32, 30'd33,
                 30'd1000000006, 30'd1000000007, 30'd1000000008, 30'd1000000005,
                 30'h3FFFFFFF, 30'h3FFFFFFE, 30'h20000000, 30'h20000001, 30'h1FFFFFFF,
                 30'h2AAAAAAA, 30'h15555555};
    foreach (directed[k]) send_count(directed[k]);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PHASE_LEN) begin
        send_idle_pct = 59;
        recv_idle_pct = 11;
      end else if (i == 2 * PHASE_LEN) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_count(random_count());
    end
    @(negedge clk);
    items.valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #15000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/ctpm_pkg.sv
rtl/ctpm_in_if.sv
rtl/ctpm_out_if.sv
rtl/ctpm_datapath.sv
rtl/ctpm_ctrl.sv
rtl/count_times_pow2_mod_prime_core.sv
tb/ctpm_residue_check.sv
tb/tb_top.sv
